// ===== design/cchst_pkg.sv =====
package cchst_pkg;

    // field limits of the calendar
    localparam logic [5:0]  SECOND_MAX = 6'd59;
    localparam logic [5:0]  MINUTE_MAX = 6'd59;
    localparam logic [4:0]  HOUR_MAX   = 5'd23;
    localparam logic [3:0]  MONTH_MAX  = 4'd12;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [11:0] YEAR_MIN   = 12'd2000;
    localparam logic [11:0] YEAR_MAX   = 12'd2099;

    // reset values of the clock
    localparam logic [4:0]  DAY_RESET   = 5'd1;
    localparam logic [3:0]  MONTH_RESET = 4'd1;
    localparam logic [11:0] YEAR_RESET  = 12'd2000;

    // request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // month lengths, january first
    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };
    localparam logic [4:0] DAYS_DEFAULT = 5'd31;

    // reciprocal of 25 for a 12-bit year: floor(y * 5243 / 2^17) == y / 25
    localparam logic [12:0] RECIP_25   = 13'd5243;
    localparam int          RECIP_SHIFT = 17;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } time_t;

    typedef struct packed {
        logic        req_type;
        logic [5:0]  set_second;
        logic [5:0]  set_minute;
        logic [4:0]  set_hour;
        logic [4:0]  set_day;
        logic [3:0]  set_month;
        logic [11:0] set_year;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  second_now;
        logic [5:0]  minute_now;
        logic [4:0]  hour_now;
        logic [4:0]  day_now;
        logic [3:0]  month_now;
        logic [11:0] year_now;
        logic        second_advanced;
        logic        load_rejected;
    } out_item_t;

    // gregorian leap rule; given y % 4 == 0, y % 100 == 0 iff y % 25 == 0,
    // and y % 400 == 0 iff also y % 16 == 0
    function automatic logic is_leap(input logic [11:0] y);
        logic [24:0] prod;
        logic [7:0]  q;
        logic [12:0] back;
        logic        div25;
        prod  = {1'b0, y} * {12'd0, RECIP_25};
        q     = prod[RECIP_SHIFT +: 8];
        back  = {1'b0, q, 4'd0} + {2'b0, q, 3'd0} + {5'd0, q};
        div25 = (back == {1'b0, y});
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    // length of a month in a given year
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic [11:0] year);
        logic [3:0] idx;
        logic [4:0] d;
        idx = month - 4'd1;
        if (month == 4'd0 || month > MONTH_MAX) begin
            d = DAYS_DEFAULT;
        end else begin
            d = MONTH_LEN[idx];
            if (month == MONTH_FEB && is_leap(year)) begin
                d = d + 5'd1;
            end
        end
        return d;
    endfunction

endpackage

// ===== design/cchst_advance.sv =====
module cchst_advance
    import cchst_pkg::*;
(
    input  time_t       cur,
    input  logic [11:0] rollover_year,
    output time_t       nxt
);

    logic sec_wrap;
    logic min_wrap;
    logic hour_wrap;
    logic day_wrap;
    logic month_wrap;
    logic year_wrap;

    // carry chain from seconds up to the year
    always_comb begin
        sec_wrap   = (cur.second >= SECOND_MAX);
        min_wrap   = sec_wrap && (cur.minute >= MINUTE_MAX);
        hour_wrap  = min_wrap && (cur.hour >= HOUR_MAX);
        day_wrap   = hour_wrap && (cur.day >= days_in(cur.month, cur.year));
        month_wrap = day_wrap && (cur.month >= MONTH_MAX);
        year_wrap  = month_wrap && (cur.year >= YEAR_MAX);
    end

    // next value of each field
    always_comb begin
        nxt = cur;
        nxt.second = sec_wrap ? 6'd0 : cur.second + 6'd1;
        if (sec_wrap) begin
            nxt.minute = min_wrap ? 6'd0 : cur.minute + 6'd1;
        end
        if (min_wrap) begin
            nxt.hour = hour_wrap ? 5'd0 : cur.hour + 5'd1;
        end
        if (hour_wrap) begin
            nxt.day = day_wrap ? DAY_RESET : cur.day + 5'd1;
        end
        if (day_wrap) begin
            nxt.month = month_wrap ? MONTH_RESET : cur.month + 4'd1;
        end
        if (month_wrap) begin
            nxt.year = year_wrap ? rollover_year : cur.year + 12'd1;
        end
    end

endmodule

// ===== design/cchst_load_check.sv =====
module cchst_load_check
    import cchst_pkg::*;
(
    input  in_item_t item,
    output logic     load_ok
);

    logic time_ok;
    logic date_ok;

    // range check of every field, the day against its month
    always_comb begin
        time_ok = (item.set_second <= SECOND_MAX) && (item.set_minute <= MINUTE_MAX)
                  && (item.set_hour <= HOUR_MAX);
        date_ok = (item.set_month != 4'd0) && (item.set_month <= MONTH_MAX)
                  && (item.set_year >= YEAR_MIN) && (item.set_year <= YEAR_MAX)
                  && (item.set_day != 5'd0)
                  && (item.set_day <= days_in(item.set_month, item.set_year));
        load_ok = time_ok && date_ok;
    end

endmodule

// ===== design/calendar_clock_half_second_tick.sv =====
// Calendar clock fed by half-second ticks and load requests. Each input item
// gives exactly one result item holding the time after it; a new item is
// taken every cycle unless the output stalls, and its result passes through
// the input register, then the result register. The rate is set by the
// combinational carry chain from seconds to year with the leap-year check.
// A load is checked field by field and against the month length, and a
// refused load leaves the clock and its half-second phase as they were.
// The user must set the rollover year via cfg only while idle (unenforced).
module calendar_clock_half_second_tick
    import cchst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);

    in_item_t    in_reg;
    logic        in_valid_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;
    time_t       time_reg;
    time_t       time_next;
    logic        phase_reg;
    logic        phase_next;
    logic [11:0] rollover_year_reg;
    time_t       time_adv;
    time_t       time_load;
    logic        load_ok;
    logic        advance;
    logic        adv_flag;
    logic        rej_flag;

    // handshake: the item in the input register moves on when the result slot frees
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    cchst_advance u_advance (
        .cur           (time_reg),
        .rollover_year (rollover_year_reg),
        .nxt           (time_adv)
    );

    cchst_load_check u_load_check (
        .item    (in_reg),
        .load_ok (load_ok)
    );

    // time from the load fields
    always_comb begin
        time_load.second = in_reg.set_second;
        time_load.minute = in_reg.set_minute;
        time_load.hour   = in_reg.set_hour;
        time_load.day    = in_reg.set_day;
        time_load.month  = in_reg.set_month;
        time_load.year   = in_reg.set_year;
    end

    // next state for the item in the input register
    always_comb begin
        time_next  = time_reg;
        phase_next = phase_reg;
        adv_flag   = 1'b0;
        rej_flag   = 1'b0;
        if (in_reg.req_type == REQ_TICK) begin
            phase_next = ~phase_reg;
            if (phase_reg) begin
                time_next = time_adv;
                adv_flag  = 1'b1;
            end
        end else if (load_ok) begin
            time_next  = time_load;
            phase_next = 1'b0;
        end else begin
            rej_flag = 1'b1;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            phase_reg         <= 1'b0;
            time_reg.second   <= 6'd0;
            time_reg.minute   <= 6'd0;
            time_reg.hour     <= 5'd0;
            time_reg.day      <= DAY_RESET;
            time_reg.month    <= MONTH_RESET;
            time_reg.year     <= YEAR_RESET;
            rollover_year_reg <= YEAR_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                time_reg      <= time_next;
                phase_reg     <= phase_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                rollover_year_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg.second_now      <= time_next.second;
            out_reg.minute_now      <= time_next.minute;
            out_reg.hour_now        <= time_next.hour;
            out_reg.day_now         <= time_next.day;
            out_reg.month_now       <= time_next.month;
            out_reg.year_now        <= time_next.year;
            out_reg.second_advanced <= adv_flag;
            out_reg.load_rejected   <= rej_flag;
        end
    end

    // a refused load leaves clock and phase untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_reg.req_type == REQ_LOAD && !load_ok)
            |=> ($stable(time_reg) && $stable(phase_reg)))
        else $error("refused load changed the clock");

    // the second tick of a pair reports an advance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_reg.req_type == REQ_TICK && phase_reg)
            |=> (m_valid && m_data.second_advanced && !m_data.load_rejected))
        else $error("second tick did not advance the clock");

    // input stalls only when both stages hold an item and the output waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid && !m_ready))
        else $error("input stalled without back-pressure");

endmodule
